@@ sv/spg_pkg.sv @@
// Shared types and constants for the stepper step/direction pulse generator.
// No dependencies; used by stepper_step_dir_pulse_generator_core.
package spg_pkg;

	// Default width of the step period register and the tick timer
	localparam int unsigned TIMER_WIDTH_DEF = 16;

	// Width of the step period configuration word
	localparam int unsigned CFG_WIDTH = 16;

	// Width of position and target values
	localparam int unsigned POS_WIDTH = 32;

	// Item kinds
	localparam logic [1:0] MODE_TICK = 2'd0;
	localparam logic [1:0] MODE_MOVE = 2'd1;
	localparam logic [1:0] MODE_STOP = 2'd2;

	// One input item
	typedef struct packed {
		logic [1:0]                  mode;
		logic signed [POS_WIDTH-1:0] target;
	} spg_in_t;

	// One result item
	typedef struct packed {
		logic                        step_out;
		logic                        dir_out;
		logic                        moving;
		logic signed [POS_WIDTH-1:0] position;
	} spg_out_t;

endpackage

@@ sv/stepper_step_dir_pulse_generator_core.sv @@
// Constant-speed step/direction pulse generator with absolute position tracking.
// Depends on spg_pkg for the item types and mode codes.
//
// Takes one item per clock while out_stall does not hold the result register: a
// timer tick, a move to a signed absolute target, or a stop. Each accepted item
// yields exactly one result showing the step pin, the direction pin, the moving
// flag and the position after that item. An item is registered in the input
// stage on acceptance, the motion state is updated in one pass of logic as the
// item leaves that stage, and the result is registered alongside. The update of
// position, step count and timer in one pass of logic sets that rate. A move
// arms the timer so the first step pulse comes on the next tick; each pulse is
// high for one tick and steps repeat every period+1 ticks. Write the step period
// through the cfg port only while no item is in flight; cfg_ready is always high.
module stepper_step_dir_pulse_generator_core #(
	parameter int unsigned TIMER_WIDTH = spg_pkg::TIMER_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Input item channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  spg_pkg::spg_in_t              in_data,
	// Result channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output spg_pkg::spg_out_t             out_data,
	// Step period write channel
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [spg_pkg::CFG_WIDTH-1:0] cfg_data
);

	localparam int unsigned PW = spg_pkg::POS_WIDTH;

	// Input stage
	logic                 valid_s1;
	spg_pkg::spg_in_t     in_s1;

	// Result register
	logic                 out_valid_q;
	spg_pkg::spg_out_t    out_q;

	// Configuration and motion state
	logic [TIMER_WIDTH-1:0] period_q;
	logic [PW-1:0]          position_q;
	logic                   dir_q;
	logic [PW-1:0]          steps_left_q;
	logic [TIMER_WIDTH-1:0] timer_q;
	logic                   pulse_q;
	logic                   busy_q;

	// Next state
	logic [PW-1:0]          position_d;
	logic                   dir_d;
	logic [PW-1:0]          steps_left_d;
	logic [TIMER_WIDTH-1:0] timer_d;
	logic                   pulse_d;
	logic                   busy_d;

	// Intermediate values
	logic                   advance;
	logic [TIMER_WIDTH-1:0] timer_dec;
	logic [PW-1:0]          steps_dec;
	logic [PW-1:0]          delta_fwd;
	logic [PW-1:0]          delta_rev;

	// Move the input stage forward whenever the result register is free or being taken
	assign advance   = !out_valid_q || !out_stall;
	assign in_stall  = valid_s1 && !advance;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign cfg_ready = 1'b1;

	// Capture an input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			in_s1 <= in_data;
		end
	end

	// Hold the step period
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= TIMER_WIDTH'(1);
		end else if (cfg_valid && cfg_ready) begin
			period_q <= TIMER_WIDTH'(cfg_data);
		end
	end

	// Compute the state after the item in the input stage
	always_comb begin
		position_d   = position_q;
		dir_d        = dir_q;
		steps_left_d = steps_left_q;
		timer_d      = timer_q;
		pulse_d      = pulse_q;
		busy_d       = busy_q;

		timer_dec = (timer_q != '0) ? timer_q - TIMER_WIDTH'(1) : timer_q;
		steps_dec = (steps_left_q != '0) ? steps_left_q - PW'(1) : steps_left_q;
		delta_fwd = PW'(in_s1.target) - position_q;
		delta_rev = position_q - PW'(in_s1.target);

		unique case (in_s1.mode)
			spg_pkg::MODE_TICK: begin
				if (pulse_q) begin
					// drop the pulse, nothing else this tick
					pulse_d = 1'b0;
				end else if (busy_q) begin
					if (timer_dec == '0) begin
						// issue a step and reload the timer
						timer_d      = period_q;
						pulse_d      = 1'b1;
						position_d   = dir_q ? position_q + PW'(1) : position_q - PW'(1);
						steps_left_d = steps_dec;
						if (steps_dec == '0) begin
							busy_d = 1'b0;
						end
					end else begin
						timer_d = timer_dec;
					end
				end
			end
			spg_pkg::MODE_MOVE: begin
				if (delta_fwd == '0) begin
					busy_d = 1'b0;
				end else begin
					// direction from the sign of the wrapped difference
					dir_d        = !delta_fwd[PW-1];
					steps_left_d = delta_fwd[PW-1] ? delta_rev : delta_fwd;
					timer_d      = '0;
					pulse_d      = 1'b0;
					busy_d       = 1'b1;
				end
			end
			spg_pkg::MODE_STOP: begin
				busy_d  = 1'b0;
				pulse_d = 1'b0;
			end
			default: begin
				// unused code: keep state
			end
		endcase
	end

	// Update motion state as the item leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q   <= '0;
			dir_q        <= 1'b0;
			steps_left_q <= '0;
			timer_q      <= '0;
			pulse_q      <= 1'b0;
			busy_q       <= 1'b0;
		end else if (valid_s1 && advance) begin
			position_q   <= position_d;
			dir_q        <= dir_d;
			steps_left_q <= steps_left_d;
			timer_q      <= timer_d;
			pulse_q      <= pulse_d;
			busy_q       <= busy_d;
		end
	end

	// Load the result register, or release it after its transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			out_q.step_out <= pulse_d;
			out_q.dir_out  <= dir_d;
			out_q.moving   <= busy_d;
			out_q.position <= position_d;
		end
	end

endmodule
